// ===== hw/rtl/ospid_pkg.sv =====
// shared types and constants of the one-sided pid speed controller
package ospid_pkg;

  localparam int unsigned ErrW      = 16;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned GainW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SpeedW    = 28;
  localparam int unsigned DivCntW   = $clog2(ErrW);

  localparam logic signed [ErrW-1:0] ErrBigLimit    = 16'sd5000;
  localparam logic signed [ErrW-1:0] ErrReplacement = 16'sd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_DIV   = 3'd0,
    CFG_INTEG_DIV  = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_INTEG_LO   = 3'd3,
    CFG_INTEG_HI   = 3'd4,
    CFG_DUTY_MIN   = 3'd5,
    CFG_DUTY_MAX   = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIVP = 5'b00100,
    ST_DIVI = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [ErrW-1:0]  dividend;
    logic [GainW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ErrW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/ospid_div.sv =====
// restoring divider, one quotient bit per cycle
module ospid_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ospid_pkg::div_req_t req_i,
  output ospid_pkg::div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [ospid_pkg::DivCntW-1:0]       cnt_q;
  logic [ospid_pkg::GainW-1:0]         rem_q;
  logic [ospid_pkg::GainW-1:0]         dsr_q;
  logic [ospid_pkg::ErrW-1:0]          quo_q;
  logic [ospid_pkg::GainW:0]           shifted;
  logic [ospid_pkg::GainW:0]           diff;
  logic                                fits;

  assign shifted = {rem_q, quo_q[ospid_pkg::ErrW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = !diff[ospid_pkg::GainW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ospid_pkg::DivCntW'(ospid_pkg::ErrW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[ospid_pkg::ErrW-2:0], fits};
      rem_q <= fits ? diff[ospid_pkg::GainW-1:0] : shifted[ospid_pkg::GainW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hw/rtl/one_sided_pid_motor_speed.sv =====
// one-sided pid motor speed controller, top level
//
//  channel   | dir | fields (low bit up)
//  s_axis    | in  | tdata: error_in[15:0]
//  m_axis    | out | tdata: duty_out[7:0], error_writeback[23:8]
//  cfg       | in  | cfg_addr_i: register index, cfg_data_i: value
//
// an item with a negative error passes through the prep, p-division, i-division and
// final steps; a non-negative one goes from prep straight to the final step. the
// shared bit-serial divider works out the p term and then the i term.
// reset clears the state, the registers and the output slot.
// the next item is taken while a result still waits on m_axis; a stalled
// result holds the block in its final step until it is taken.
// configuration writes are taken only while the block is idle.
module one_sided_pid_motor_speed (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // error_in[15:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,   // duty_out, error_writeback
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ospid_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [ospid_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned EW = ospid_pkg::ErrW;
  localparam int unsigned SW = ospid_pkg::SpeedW;

  ospid_pkg::state_e state_q, state_d;

  logic [ospid_pkg::GainW-1:0]  prop_div_q, integ_div_q, deriv_gain_q;
  logic signed [EW-1:0]         integ_lo_q, integ_hi_q;
  logic [ospid_pkg::DutyW-1:0]  duty_min_q, duty_max_q;

  logic signed [EW-1:0]         integ_q;
  logic [EW-1:0]                last_mag_q;

  logic signed [EW-1:0]         err_q;
  logic signed [EW-1:0]         wbw_q;
  logic signed [SW-1:0]         dterm_q;
  logic signed [SW-1:0]         acc_q;

  logic                         out_valid_q;
  logic [ospid_pkg::DutyW-1:0]  duty_q;
  logic signed [EW-1:0]         wb_q;

  logic                         s_accept, cfg_accept, out_free;
  logic [EW-1:0]                mag;
  logic signed [EW+1:0]         integ_sum, integ_lo_x, integ_hi_x;
  logic signed [EW-1:0]         integ_new;
  logic signed [EW+1:0]         mag_diff;
  logic signed [EW+ospid_pkg::GainW+2:0] dprod;
  logic [EW-1:0]                integ_abs;
  logic signed [EW:0]           iterm;
  logic signed [SW-1:0]         dmin_x, dmax_x;
  logic [ospid_pkg::DutyW-1:0]  duty_clamped;
  logic signed [EW-1:0]         wb_new;
  logic [ospid_pkg::GainW-1:0]  pdiv_eff, idiv_eff;

  ospid_pkg::div_req_t div_req;
  ospid_pkg::div_rsp_t div_rsp;

  assign s_axis_tready = (state_q == ospid_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == ospid_pkg::ST_IDLE);
  assign cfg_accept    = cfg_valid_i && cfg_ready_o;
  assign out_free      = !out_valid_q || m_axis_tready;

  // magnitude of a negative error, 32768 included
  assign mag = EW'(~err_q) + 1'b1;

  assign integ_sum  = EW'(0) + {{2{integ_q[EW-1]}}, integ_q} + {2'b00, mag};
  assign integ_lo_x = {{2{integ_lo_q[EW-1]}}, integ_lo_q};
  assign integ_hi_x = {{2{integ_hi_q[EW-1]}}, integ_hi_q};

  always_comb begin
    priority if (integ_sum < integ_lo_x) begin
      integ_new = integ_lo_q;
    end else if (integ_sum > integ_hi_x) begin
      integ_new = integ_hi_q;
    end else begin
      integ_new = integ_sum[EW-1:0];
    end
  end

  assign mag_diff = $signed({2'b00, mag}) - $signed({2'b00, last_mag_q});
  assign dprod    = mag_diff * $signed({1'b0, deriv_gain_q});

  assign integ_abs = integ_q[EW-1] ? EW'(~integ_q) + 1'b1 : integ_q;
  assign iterm     = integ_q[EW-1] ? -$signed({1'b0, div_rsp.quotient})
                                   : $signed({1'b0, div_rsp.quotient});

  assign pdiv_eff = (prop_div_q == '0) ? ospid_pkg::GainW'(1) : prop_div_q;
  assign idiv_eff = (integ_div_q == '0) ? ospid_pkg::GainW'(1) : integ_div_q;

  assign dmin_x = $signed({{(SW-ospid_pkg::DutyW){1'b0}}, duty_min_q});
  assign dmax_x = $signed({{(SW-ospid_pkg::DutyW){1'b0}}, duty_max_q});

  always_comb begin
    priority if (acc_q < dmin_x) begin
      duty_clamped = duty_min_q;
    end else if (acc_q > dmax_x) begin
      duty_clamped = duty_max_q;
    end else begin
      duty_clamped = acc_q[ospid_pkg::DutyW-1:0];
    end
  end

  always_comb begin
    priority if ($signed(s_axis_tdata) < -ospid_pkg::ErrBigLimit) begin
      wb_new = -ospid_pkg::ErrReplacement;
    end else if ($signed(s_axis_tdata) > ospid_pkg::ErrBigLimit) begin
      wb_new = ospid_pkg::ErrReplacement;
    end else begin
      wb_new = $signed(s_axis_tdata);
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = mag;
    div_req.divisor  = pdiv_eff;
    if (state_q == ospid_pkg::ST_DIVP) begin
      div_req.dividend = integ_abs;
      div_req.divisor  = idiv_eff;
      div_req.start    = div_rsp.done;
    end else if (state_q == ospid_pkg::ST_PREP) begin
      div_req.start    = err_q[EW-1];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ospid_pkg::ST_IDLE: if (s_accept) state_d = ospid_pkg::ST_PREP;
      ospid_pkg::ST_PREP: state_d = err_q[EW-1] ? ospid_pkg::ST_DIVP : ospid_pkg::ST_FIN;
      ospid_pkg::ST_DIVP: if (div_rsp.done) state_d = ospid_pkg::ST_DIVI;
      ospid_pkg::ST_DIVI: if (div_rsp.done) state_d = ospid_pkg::ST_FIN;
      ospid_pkg::ST_FIN:  if (out_free) state_d = ospid_pkg::ST_IDLE;
      default:            state_d = ospid_pkg::ST_IDLE;
    endcase
  end

  ospid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ospid_pkg::ST_IDLE;
      prop_div_q   <= ospid_pkg::GainW'(1);
      integ_div_q  <= ospid_pkg::GainW'(1);
      deriv_gain_q <= '0;
      integ_lo_q   <= '0;
      integ_hi_q   <= 16'sh7fff;
      duty_min_q   <= '0;
      duty_max_q   <= '1;
      integ_q      <= '0;
      last_mag_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_accept) begin
        unique case (ospid_pkg::cfg_idx_e'(cfg_addr_i))
          ospid_pkg::CFG_PROP_DIV:   prop_div_q   <= cfg_data_i[ospid_pkg::GainW-1:0];
          ospid_pkg::CFG_INTEG_DIV:  integ_div_q  <= cfg_data_i[ospid_pkg::GainW-1:0];
          ospid_pkg::CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[ospid_pkg::GainW-1:0];
          ospid_pkg::CFG_INTEG_LO:   integ_lo_q   <= $signed(cfg_data_i);
          ospid_pkg::CFG_INTEG_HI:   integ_hi_q   <= $signed(cfg_data_i);
          ospid_pkg::CFG_DUTY_MIN:   duty_min_q   <= cfg_data_i[ospid_pkg::DutyW-1:0];
          ospid_pkg::CFG_DUTY_MAX:   duty_max_q   <= cfg_data_i[ospid_pkg::DutyW-1:0];
          default: ;
        endcase
      end
      if (state_q == ospid_pkg::ST_PREP && err_q[EW-1]) begin
        integ_q    <= integ_new;
        last_mag_q <= mag;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ospid_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      err_q <= $signed(s_axis_tdata);
      wbw_q <= wb_new;
    end
    unique case (state_q)
      ospid_pkg::ST_PREP: begin
        dterm_q <= SW'(dprod);
        acc_q   <= '0;
      end
      ospid_pkg::ST_DIVP: begin
        if (div_rsp.done) begin
          acc_q <= $signed({{(SW-EW){1'b0}}, div_rsp.quotient}) - dterm_q;
        end
      end
      ospid_pkg::ST_DIVI: begin
        if (div_rsp.done) begin
          acc_q <= acc_q + SW'(iterm);
        end
      end
      ospid_pkg::ST_FIN: begin
        if (out_free) begin
          duty_q <= duty_clamped;
          wb_q   <= wbw_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {wb_q, duty_q};

endmodule

// ===== hw/rtl/ospid_chk.sv =====
// port-level checks of the pid speed controller, bound to the top level
module ospid_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [23:0]                    m_axis_tdata
);

  // busy after every accepted item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block ready right after an accepted item");

  // write-back never leaves the band of plus or minus ErrBigLimit
  a_wb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[23:8]) >= -ospid_pkg::ErrBigLimit)
                   && ($signed(m_axis_tdata[23:8]) <= ospid_pkg::ErrBigLimit))
    else $error("error write-back outside its band");

  // a new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind one_sided_pid_motor_speed ospid_chk u_ospid_chk (.*);

// ===== dv/one_sided_pid_motor_speed_tb.sv =====
// self-checking testbench for the one-sided pid motor speed controller
module one_sided_pid_motor_speed_tb;
  import ospid_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomSegs  = 8;
  localparam int unsigned SegItems    = 85;

  localparam logic [ErrW-1:0] DirectedErrs [21] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd5000, 16'sd5001, -16'sd5000, -16'sd5001,
    16'sd32767, -16'sd32767, 16'h8000, -16'sd2, -16'sd300, -16'sd300,
    -16'sd10, 16'sd4999, -16'sd4999, 16'h5555, 16'hAAAA, -16'sd1, 16'sd100,
    16'h8000
  };

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [ErrW-1:0]  wb;
  } tick_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;   // error_in[15:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;         // duty_out[7:0], error_writeback[23:8]
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // predictor copy of the registers and state
  logic [GainW-1:0]       prop_div_m   = 8'd1;
  logic [GainW-1:0]       integ_div_m  = 8'd1;
  logic [GainW-1:0]       deriv_gain_m = 8'd0;
  logic signed [ErrW-1:0] integ_lo_m   = 16'sd0;
  logic signed [ErrW-1:0] integ_hi_m   = 16'sd32767;
  logic [DutyW-1:0]       duty_min_m   = 8'd0;
  logic [DutyW-1:0]       duty_max_m   = 8'd255;
  logic signed [ErrW-1:0] integ_acc_m  = '0;
  logic [ErrW-1:0]        last_mag_m   = '0;

  logic [ErrW-1:0] pending_errors [$];
  tick_result_t    tick_results_q [$];
  int              idle_pct   = 0;
  int              stall_pct  = 0;
  int              mismatches = 0;
  int              cycles     = 0;

  one_sided_pid_motor_speed dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic pid_tick(input logic [ErrW-1:0] raw);
    longint       err;
    longint       mag;
    longint       pdiv;
    longint       idiv;
    longint       acc;
    longint       speed;
    tick_result_t res;
    err    = longint'($signed(raw));
    res.wb = raw;
    if (err < -longint'(ErrBigLimit)) begin
      res.wb = -ErrReplacement;
    end else if (err > longint'(ErrBigLimit)) begin
      res.wb = ErrReplacement;
    end
    speed = 0;
    if (err < 0) begin
      mag  = -err;
      pdiv = (prop_div_m == 0) ? 1 : longint'(prop_div_m);
      idiv = (integ_div_m == 0) ? 1 : longint'(integ_div_m);
      acc  = longint'(integ_acc_m) + mag;
      if (acc < longint'(integ_lo_m)) begin
        acc = longint'(integ_lo_m);
      end else if (acc > longint'(integ_hi_m)) begin
        acc = longint'(integ_hi_m);
      end
      integ_acc_m = acc[ErrW-1:0];
      speed = mag / pdiv + acc / idiv
              - (mag - longint'(last_mag_m)) * longint'(deriv_gain_m);
      last_mag_m = mag[ErrW-1:0];
    end
    if (speed < longint'(duty_min_m)) begin
      speed = longint'(duty_min_m);
    end else if (speed > longint'(duty_max_m)) begin
      speed = longint'(duty_max_m);
    end
    res.duty = speed[DutyW-1:0];
    tick_results_q.push_back(res);
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PROP_DIV:   prop_div_m   = value[7:0];
      CFG_INTEG_DIV:  integ_div_m  = value[7:0];
      CFG_DERIV_GAIN: deriv_gain_m = value[7:0];
      CFG_INTEG_LO:   integ_lo_m   = value;
      CFG_INTEG_HI:   integ_hi_m   = value;
      CFG_DUTY_MIN:   duty_min_m   = value[7:0];
      CFG_DUTY_MAX:   duty_max_m   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic program_gains(input int seg);
    logic [7:0]  pd;
    logic [7:0]  id;
    logic [7:0]  dg;
    logic [7:0]  dmin;
    logic [7:0]  dmax;
    logic [15:0] lo;
    logic [15:0] hi;
    case (seg)
      // zero divisors, widest limits, largest derivative gain
      0: begin
        pd = 0; id = 0; dg = 255; lo = 16'h8000; hi = 16'h7FFF; dmin = 0; dmax = 255;
      end
      // crossed integral and duty limits
      1: begin
        pd = 255; id = 255; dg = 0; lo = 16'sd300; hi = -16'sd300; dmin = 200; dmax = 50;
      end
      // negative integral, truncating division
      2: begin
        pd = 3; id = 7; dg = 1; lo = 16'h8000; hi = -16'sd5; dmin = 0; dmax = 255;
      end
      3: begin
        pd = 128; id = 64; dg = 3; lo = 16'h7FFF; hi = 16'h7FFF; dmin = 100; dmax = 180;
      end
      default: begin
        pd   = 8'($urandom_range(0, 255));
        id   = 8'($urandom_range(0, 255));
        dg   = 8'($urandom_range(1) ? $urandom_range(0, 4) : $urandom_range(0, 255));
        lo   = 16'(-int'($urandom_range(0, 3000)));
        hi   = 16'($urandom_range(0, 6000));
        dmin = 8'($urandom_range(0, 80));
        dmax = 8'($urandom_range(120, 255));
      end
    endcase
    write_reg(CFG_PROP_DIV, {8'($urandom), pd});
    write_reg(CFG_INTEG_DIV, {8'($urandom), id});
    write_reg(CFG_DERIV_GAIN, {8'($urandom), dg});
    write_reg(CFG_INTEG_LO, lo);
    write_reg(CFG_INTEG_HI, hi);
    write_reg(CFG_DUTY_MIN, {8'($urandom), dmin});
    write_reg(CFG_DUTY_MAX, {8'($urandom), dmax});
  endtask

  function automatic logic [ErrW-1:0] rand_error();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) return 16'(-int'($urandom_range(1, 300)));
    if (pick < 55) return 16'(-int'($urandom_range(1, 32768)));
    if (pick < 65) return 16'(($urandom_range(1) ? 5000 : -5000) + int'($urandom_range(0, 4)) - 2);
    if (pick < 80) return 16'($urandom_range(0, 32767));
    return 16'($urandom);
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_errors.size() != 0 || s_axis_tvalid || tick_results_q.size() != 0);
  endtask

  // error item driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pid_tick(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_errors.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_errors.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // duty item monitor
  always @(posedge clk_i) begin : monitor
    tick_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tick_results_q.size() == 0) begin
          note_mismatch("unexpected result", '0, m_axis_tdata[15:0]);
        end else begin
          want = tick_results_q.pop_front();
          if (m_axis_tdata[7:0] !== want.duty) begin
            note_mismatch("duty_out", 16'(want.duty), 16'(m_axis_tdata[7:0]));
          end
          if (m_axis_tdata[23:8] !== want.wb) begin
            note_mismatch("error_writeback", want.wb, m_axis_tdata[23:8]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAIL one_sided_pid_motor_speed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(CFG_UNUSED, 16'($urandom));
    foreach (DirectedErrs[k]) pending_errors.push_back(DirectedErrs[k]);
    wait_drained();
    for (int s = 0; s < RandomSegs; s++) begin
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      program_gains(s);
      repeat (SegItems) pending_errors.push_back(rand_error());
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && tick_results_q.size() == 0) begin
      $display("PASS one_sided_pid_motor_speed");
    end else begin
      $display("FAIL one_sided_pid_motor_speed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ospid_pkg.sv
hw/rtl/ospid_div.sv
hw/rtl/one_sided_pid_motor_speed.sv
hw/rtl/ospid_chk.sv
dv/one_sided_pid_motor_speed_tb.sv
